// File: rtl/taw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package taw_pkg;

   localparam int TIME_W  = 48;
   localparam int COUNT_W = 32;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_KEYING  = 2'd1;
   localparam logic [1:0] ST_ONAIR   = 2'd2;
   localparam logic [1:0] ST_NOAUDIO = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0]  stamp;
      logic [COUNT_W-1:0] count;
   } taw_entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } taw_cell_ctl_type;

endpackage
`default_nettype wire

// File: rtl/tx_audio_flow_watchdog.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall req_operation, req_tx_active, req_packet_count,
//                                         req_now_ms
// rsp      out        rsp_valid/rsp_stall rsp_tx_state, rsp_flowing, rsp_silent_ms,
//                                         rsp_stall_event
// csr      in         csr_wr_en           csr_index, csr_wdata
//
// A keyed sample request steps through push, age (popping the aged window entries), evaluate,
// decide and done; the window is a row of cells that shifts down one entry per cycle, one pop
// per cycle. An unkeyed sample request steps through push and done, a take request through
// take and done. One request is in work at a time. Reset is synchronous; it empties the window
// and holds req_stall high. A stalled response holds in the output register; the block
// finishes its request and then waits for that register to drain before taking the next one.
module tx_audio_flow_watchdog #(
   parameter int WINDOW_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_operation,
   input  wire logic        req_tx_active,
   input  wire logic [31:0] req_packet_count,
   input  wire logic [47:0] req_now_ms,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_tx_state,
   output logic             rsp_flowing,
   output logic [31:0]      rsp_silent_ms,
   output logic             rsp_stall_event,
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam int IW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int FW = $clog2(WINDOW_DEPTH + 1);

   localparam logic [7:0] REG_FLOW_WINDOW  = 8'd0;
   localparam logic [7:0] REG_FLOW_PACKETS = 8'd1;
   localparam logic [7:0] REG_GRACE        = 8'd2;
   localparam logic [7:0] REG_STALL        = 8'd3;

   typedef enum logic [2:0] {
      S_IDLE, S_PUSH, S_AGE, S_EVAL, S_DECIDE, S_TAKE, S_DONE
   } seq_type;

   seq_type state_ff;

   logic [15:0] flow_window_ff;
   logic [7:0]  flow_packets_ff;
   logic [15:0] grace_ff;
   logic [15:0] stall_ms_ff;

   logic        keyed_ff;
   logic [31:0] cnt_ff;
   logic [47:0] now_ff;

   logic [FW-1:0] fill_ff;
   logic [31:0]   prev_count_ff;
   logic [1:0]    mon_state_ff;
   logic          was_keyed_ff;
   logic          has_flowed_ff;
   logic          flow_ff;
   logic [31:0]   silence_ff;
   logic [47:0]   last_flow_ff;
   logic          stall_wait_ff;
   logic          stall_used_ff;
   logic          event_ff;

   logic          eval_flow_ff;
   logic [47:0]   diff_ff;

   logic [1:0]  rsp_state_ff;
   logic        rsp_flow_ff;
   logic [31:0] rsp_silent_ff;
   logic        rsp_event_ff;
   logic        rsp_valid_ff;

   taw_pkg::taw_entry_type    entries [WINDOW_DEPTH];
   taw_pkg::taw_cell_ctl_type ctls    [WINDOW_DEPTH];
   taw_pkg::taw_entry_type    sample_entry;

   logic          clear;
   logic [FW-1:0] eff_fill;
   logic          full;
   logic [IW-1:0] wr_idx;
   logic [FW-1:0] fill_in;
   logic          push;
   logic          aged;
   logic          pop;
   logic [31:0]   delta;
   logic          eval_flow_in;
   logic [48:0]   diff_wide;
   logic [47:0]   diff_in;
   logic [31:0]   silence_sat;
   logic          out_free;

   assign sample_entry.stamp = now_ff;
   assign sample_entry.count = cnt_ff;

   assign clear    = (cnt_ff < prev_count_ff) || !keyed_ff || !was_keyed_ff;
   assign eff_fill = clear ? '0 : fill_ff;
   assign full     = (eff_fill == FW'(WINDOW_DEPTH));
   assign wr_idx   = full ? IW'(WINDOW_DEPTH - 1) : eff_fill[IW-1:0];
   assign fill_in  = full ? FW'(WINDOW_DEPTH) : FW'(eff_fill + 1'b1);
   assign push     = (state_ff == S_PUSH);

   assign aged = (fill_ff > FW'(2)) &&
                 (({1'b0, entries[1].stamp} + {33'b0, flow_window_ff}) <= {1'b0, now_ff});
   assign pop  = (state_ff == S_AGE) && aged;

   genvar gi;
   generate
      for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
         assign ctls[gi].load  = push && (wr_idx == IW'(gi));
         assign ctls[gi].shift = pop || (push && full);
         if (gi == WINDOW_DEPTH - 1) begin : g_last
            taw_cell u_cell (
               .clock      (clock),
               .ctl        (ctls[gi]),
               .new_entry  (sample_entry),
               .next_entry (entries[gi]),
               .entry      (entries[gi])
            );
         end else begin : g_mid
            taw_cell u_cell (
               .clock      (clock),
               .ctl        (ctls[gi]),
               .new_entry  (sample_entry),
               .next_entry (entries[gi+1]),
               .entry      (entries[gi])
            );
         end
      end
   endgenerate

   assign delta        = cnt_ff - entries[0].count;
   assign eval_flow_in = (delta >= {24'b0, flow_packets_ff});
   assign diff_wide    = {1'b0, now_ff} - {1'b0, last_flow_ff};
   assign diff_in      = diff_wide[48] ? '0 : diff_wide[47:0];
   assign silence_sat  = (|diff_ff[47:32]) ? 32'hFFFF_FFFF : diff_ff[31:0];
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         flow_window_ff  <= 16'd1000;
         flow_packets_ff <= 8'd3;
         grace_ff        <= 16'd1500;
         stall_ms_ff     <= 16'd3000;
         fill_ff         <= '0;
         prev_count_ff   <= '0;
         mon_state_ff    <= taw_pkg::ST_IDLE;
         was_keyed_ff    <= 1'b0;
         has_flowed_ff   <= 1'b0;
         flow_ff         <= 1'b0;
         silence_ff      <= '0;
         last_flow_ff    <= '0;
         stall_wait_ff   <= 1'b0;
         stall_used_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_FLOW_WINDOW:  flow_window_ff  <= csr_wdata;
               REG_FLOW_PACKETS: flow_packets_ff <= csr_wdata[7:0];
               REG_GRACE:        grace_ff        <= csr_wdata;
               REG_STALL:        stall_ms_ff     <= csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  keyed_ff <= req_tx_active;
                  cnt_ff   <= req_packet_count;
                  now_ff   <= req_now_ms;
                  event_ff <= 1'b0;
                  state_ff <= req_operation ? S_TAKE : S_PUSH;
               end
            end
            S_PUSH: begin
               fill_ff       <= fill_in;
               prev_count_ff <= cnt_ff;
               if (!keyed_ff) begin
                  mon_state_ff  <= taw_pkg::ST_IDLE;
                  was_keyed_ff  <= 1'b0;
                  flow_ff       <= 1'b0;
                  silence_ff    <= '0;
                  stall_wait_ff <= 1'b0;
                  state_ff      <= S_DONE;
               end else begin
                  if (!was_keyed_ff) begin
                     was_keyed_ff  <= 1'b1;
                     has_flowed_ff <= 1'b0;
                     stall_used_ff <= 1'b0;
                     stall_wait_ff <= 1'b0;
                     last_flow_ff  <= now_ff;
                  end
                  state_ff <= S_AGE;
               end
            end
            S_AGE: begin
               if (aged) begin
                  fill_ff <= FW'(fill_ff - 1'b1);
               end else begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               eval_flow_ff <= eval_flow_in;
               diff_ff      <= diff_in;
               state_ff     <= S_DECIDE;
            end
            S_DECIDE: begin
               flow_ff <= eval_flow_ff;
               if (eval_flow_ff) begin
                  has_flowed_ff <= 1'b1;
                  last_flow_ff  <= now_ff;
                  silence_ff    <= '0;
                  mon_state_ff  <= taw_pkg::ST_ONAIR;
               end else begin
                  silence_ff <= silence_sat;
                  if (diff_ff < {32'b0, grace_ff}) begin
                     mon_state_ff <= has_flowed_ff ? taw_pkg::ST_ONAIR : taw_pkg::ST_KEYING;
                  end else begin
                     mon_state_ff <= taw_pkg::ST_NOAUDIO;
                     if ((diff_ff >= {32'b0, stall_ms_ff}) && !stall_used_ff) begin
                        stall_wait_ff <= 1'b1;
                     end
                  end
               end
               state_ff <= S_DONE;
            end
            S_TAKE: begin
               if (stall_wait_ff) begin
                  stall_wait_ff <= 1'b0;
                  stall_used_ff <= 1'b1;
                  event_ff      <= 1'b1;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_state_ff  <= mon_state_ff;
                  rsp_flow_ff   <= flow_ff;
                  rsp_silent_ff <= silence_ff;
                  rsp_event_ff  <= event_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall       = reset || (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tx_state    = rsp_state_ff;
   assign rsp_flowing     = rsp_flow_ff;
   assign rsp_silent_ms   = rsp_silent_ff;
   assign rsp_stall_event = rsp_event_ff;

endmodule
`default_nettype wire

// File: rtl/taw_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module taw_cell (
   input  wire logic                      clock,
   input  wire taw_pkg::taw_cell_ctl_type ctl,
   input  wire taw_pkg::taw_entry_type    new_entry,
   input  wire taw_pkg::taw_entry_type    next_entry,
   output taw_pkg::taw_entry_type         entry
);

   taw_pkg::taw_entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         entry_ff <= new_entry;
      end else if (ctl.shift) begin
         entry_ff <= next_entry;
      end
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire
